@@ rtl/nmea_rmc_pkg.sv @@
`timescale 1ns / 1ps

package nmea_rmc_pkg;

  // Sentence length limit; a sentence that grows past it is dropped.
  localparam int MAX_STORED_DEFAULT = 90;

  localparam int NUM_FIELDS  = 9;
  localparam int FIELD_CHARS = 10;
  localparam int TEXT_W      = 8 * FIELD_CHARS;
  localparam int IDX_W       = $clog2(NUM_FIELDS);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [3:0] COMMA_SAT  = 4'd10;
  localparam logic [3:0] LAST_FIELD = 4'd9;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_WRITE,
    CMD_EMIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] field;
    logic [3:0] pos;
    logic [7:0] data;
  } cmd_t;

  // Width of each field in characters; zero for codes that are no field.
  function automatic logic [3:0] field_len(input logic [3:0] f);
    logic [3:0] len;
    case (f)
      4'd1:    len = 4'd10;
      4'd2:    len = 4'd1;
      4'd3:    len = 4'd9;
      4'd4:    len = 4'd1;
      4'd5:    len = 4'd10;
      4'd6:    len = 4'd1;
      4'd7:    len = 4'd5;
      4'd8:    len = 4'd5;
      4'd9:    len = 4'd6;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Single-character fields take the last character given.
  function automatic logic field_multi(input logic [3:0] f);
    return field_len(f) > 4'd1;
  endfunction

  // Text a field holds at the start of a sentence.
  function automatic logic [TEXT_W-1:0] template_text(input logic [3:0] f);
    logic [TEXT_W-1:0] t;
    logic [3:0]        len;
    len = field_len(f);
    t   = '0;
    for (int i = 0; i < FIELD_CHARS; i++) begin
      if (4'(i) < len) begin
        t[8*i +: 8] = CH_ZERO;
      end
    end
    case (f)
      4'd1:    t[8*6 +: 8] = CH_DOT;
      4'd2:    t[7:0]      = CH_V;
      4'd3:    t[8*4 +: 8] = CH_DOT;
      4'd4:    t[7:0]      = CH_N;
      4'd5:    t[8*5 +: 8] = CH_DOT;
      4'd6:    t[7:0]      = CH_E;
      4'd7:    t[8*3 +: 8] = CH_DOT;
      4'd8:    t[8*3 +: 8] = CH_DOT;
      default: t = t;
    endcase
    return t;
  endfunction

endpackage

@@ rtl/nmea_rmc_if.sv @@
`timescale 1ns / 1ps

// Serial byte channel.
interface nmea_rmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Field result channel.
interface nmea_rmc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_number;
  logic [63:0] text_low;
  logic [15:0] text_high;
  logic        last_field;

  modport source (output valid, output field_number, output text_low, output text_high,
                  output last_field, input ready);
  modport sink (input valid, input field_number, input text_low, input text_high,
                input last_field, output ready);
endinterface

@@ rtl/nmea_rmc_front.sv @@
`timescale 1ns / 1ps

module nmea_rmc_front #(
  parameter int MAX_STORED = nmea_rmc_pkg::MAX_STORED_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  nmea_rmc_in_if.sink          serial,
  input  logic                 q_full,
  output logic                 push,
  output nmea_rmc_pkg::cmd_t   push_cmd
);

  localparam int CntW = $clog2(MAX_STORED + 2);

  nmea_rmc_pkg::phase_t phase, phase_next;
  logic [CntW-1:0]      stored_count, stored_count_next;
  logic [3:0]           comma_count, comma_count_next;
  logic [3:0]           char_index, char_index_next;
  logic                 scan_stopped, scan_stopped_next;
  logic                 hdr_ok, hdr_ok_next;
  logic                 cmd_valid;
  nmea_rmc_pkg::cmd_t   cmd;
  logic                 accept;

  assign serial.ready = !q_full;
  assign accept       = serial.valid && serial.ready;
  assign push         = accept && cmd_valid;
  assign push_cmd     = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= nmea_rmc_pkg::PH_HUNT;
      stored_count <= '0;
      comma_count  <= '0;
      char_index   <= '0;
      scan_stopped <= 1'b0;
      hdr_ok       <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      stored_count <= stored_count_next;
      comma_count  <= comma_count_next;
      char_index   <= char_index_next;
      scan_stopped <= scan_stopped_next;
      hdr_ok       <= hdr_ok_next;
    end
  end

  always_comb begin
    logic [7:0]      b;
    logic [CntW-1:0] cnt;
    logic            store_en;
    b                 = serial.rx_byte;
    phase_next        = phase;
    cnt               = stored_count;
    comma_count_next  = comma_count;
    char_index_next   = char_index;
    scan_stopped_next = scan_stopped;
    hdr_ok_next       = hdr_ok;
    cmd_valid         = 1'b0;
    cmd               = '{kind: nmea_rmc_pkg::CMD_WRITE, field: '0, pos: '0, data: b};
    store_en          = 1'b0;

    if (stored_count > CntW'(MAX_STORED)) begin
      phase_next = nmea_rmc_pkg::PH_HUNT;
      cnt        = '0;
    end

    case (phase_next)
      nmea_rmc_pkg::PH_HUNT: begin
        if (b == nmea_rmc_pkg::CH_DOLLAR) begin
          cmd_valid         = 1'b1;
          cmd.kind          = nmea_rmc_pkg::CMD_LOAD;
          comma_count_next  = '0;
          char_index_next   = '0;
          scan_stopped_next = 1'b0;
          store_en          = 1'b1;
        end
      end
      nmea_rmc_pkg::PH_HEAD,
      nmea_rmc_pkg::PH_BODY: store_en = 1'b1;
      default: store_en = 1'b0;
    endcase

    if (store_en) begin
      // Header letters at byte positions 3 to 5 must spell RMC.
      if (cnt == CntW'(3)) begin
        hdr_ok_next = (b == nmea_rmc_pkg::CH_R);
      end else if (cnt == CntW'(4)) begin
        hdr_ok_next = hdr_ok && (b == nmea_rmc_pkg::CH_M);
      end else if (cnt == CntW'(5)) begin
        hdr_ok_next = hdr_ok && (b == nmea_rmc_pkg::CH_C);
      end

      if (!scan_stopped_next) begin
        if (b == nmea_rmc_pkg::CH_STAR || b == nmea_rmc_pkg::CH_NUL) begin
          scan_stopped_next = 1'b1;
        end else if (b == nmea_rmc_pkg::CH_COMMA) begin
          if (comma_count_next < nmea_rmc_pkg::COMMA_SAT) begin
            comma_count_next = comma_count_next + 4'd1;
          end
          char_index_next = '0;
        end else if (comma_count_next >= 4'd1 && comma_count_next <= nmea_rmc_pkg::LAST_FIELD) begin
          if (nmea_rmc_pkg::field_multi(comma_count_next)) begin
            if (char_index_next < nmea_rmc_pkg::field_len(comma_count_next)) begin
              cmd_valid       = 1'b1;
              cmd.field       = comma_count_next;
              cmd.pos         = char_index_next;
              char_index_next = char_index_next + 4'd1;
            end
          end else begin
            cmd_valid = 1'b1;
            cmd.field = comma_count_next;
            cmd.pos   = '0;
          end
        end
      end
    end

    case (phase_next)
      nmea_rmc_pkg::PH_HUNT: begin
        if (store_en) begin
          phase_next = nmea_rmc_pkg::PH_HEAD;
          cnt        = CntW'(1);
        end
      end
      nmea_rmc_pkg::PH_HEAD: begin
        cnt = cnt + CntW'(1);
        if (cnt > CntW'(5)) begin
          if (hdr_ok_next) begin
            phase_next = nmea_rmc_pkg::PH_BODY;
          end else begin
            phase_next = nmea_rmc_pkg::PH_HUNT;
            cnt        = '0;
          end
        end
      end
      nmea_rmc_pkg::PH_BODY: begin
        cnt = cnt + CntW'(1);
        if (b == nmea_rmc_pkg::CH_STAR) begin
          cmd_valid  = 1'b1;
          cmd.kind   = nmea_rmc_pkg::CMD_EMIT;
          phase_next = nmea_rmc_pkg::PH_HUNT;
          cnt        = '0;
        end
      end
      default: phase_next = nmea_rmc_pkg::PH_HUNT;
    endcase

    stored_count_next = cnt;
  end

endmodule

@@ rtl/nmea_rmc_queue.sv @@
`timescale 1ns / 1ps

module nmea_rmc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  nmea_rmc_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               head_valid,
  output nmea_rmc_pkg::cmd_t head_cmd,
  input  logic               pop
);

  localparam int PtrW = $clog2(nmea_rmc_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(nmea_rmc_pkg::QUEUE_DEPTH + 1);

  nmea_rmc_pkg::cmd_t slots [nmea_rmc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               do_pop;

  assign full       = (count == CntW'(nmea_rmc_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/nmea_rmc_back.sv @@
`timescale 1ns / 1ps

module nmea_rmc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  nmea_rmc_pkg::cmd_t head_cmd,
  output logic               pop,
  nmea_rmc_out_if.source     fields
);

  localparam int NumF = nmea_rmc_pkg::NUM_FIELDS;
  localparam int IdxW = nmea_rmc_pkg::IDX_W;

  logic [nmea_rmc_pkg::TEXT_W-1:0] text [NumF];
  logic [3:0]                      emit_field;
  logic                            out_free;
  logic                            do_emit;
  logic [IdxW-1:0]                 wr_idx;
  logic [IdxW-1:0]                 rd_idx;
  logic [nmea_rmc_pkg::TEXT_W-1:0] rd_text;

  assign out_free = !fields.valid || fields.ready;
  assign do_emit  = head_valid && head_cmd.kind == nmea_rmc_pkg::CMD_EMIT && out_free;
  assign wr_idx   = IdxW'(head_cmd.field - 4'd1);
  assign rd_idx   = IdxW'(emit_field - 4'd1);
  assign rd_text  = text[rd_idx];

  always_comb begin
    case (head_cmd.kind)
      nmea_rmc_pkg::CMD_LOAD,
      nmea_rmc_pkg::CMD_WRITE: pop = head_valid;
      nmea_rmc_pkg::CMD_EMIT:  pop = do_emit && emit_field == nmea_rmc_pkg::LAST_FIELD;
      default:                 pop = head_valid;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_valid && head_cmd.kind == nmea_rmc_pkg::CMD_LOAD) begin
      for (int i = 0; i < NumF; i++) begin
        text[i] <= nmea_rmc_pkg::template_text(4'(i + 1));
      end
    end else if (head_valid && head_cmd.kind == nmea_rmc_pkg::CMD_WRITE) begin
      text[wr_idx][8*head_cmd.pos +: 8] <= head_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fields.valid <= 1'b0;
      emit_field   <= 4'd1;
    end else begin
      if (do_emit) begin
        fields.valid <= 1'b1;
        emit_field   <= (emit_field == nmea_rmc_pkg::LAST_FIELD) ? 4'd1 : emit_field + 4'd1;
      end else if (fields.ready) begin
        fields.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      fields.field_number <= emit_field;
      fields.text_low     <= rd_text[63:0];
      fields.text_high    <= rd_text[79:64];
      fields.last_field   <= (emit_field == nmea_rmc_pkg::LAST_FIELD);
    end
  end

endmodule

@@ rtl/nmea_rmc_sentence_parser.sv @@
`timescale 1ns / 1ps

// NMEA 0183 RMC sentence parser.
// The serial channel carries one received byte per word. The parser hunts for '$', keeps a
// sentence only when its header reads RMC, and captures fields 1 to 9 (time, status,
// latitude, N/S, longitude, E/W, speed, course, date) into a record that starts from a
// template of '0' characters, '.' markers and the letters V, N and E. When '*' closes a
// kept sentence, the fields channel gives nine words, field 1 to 9, with last_field set
// on the ninth. Characters beyond a field's width are dropped.
// Throughput: a byte is accepted in every cycle while the four-entry command queue between
// the front end and the record store has room. A closing '*' holds the record store for
// nine result words, one per field, sent through the single output register. The '*'
// passes through the command queue, and each result word is registered in the output
// register; the words follow on consecutive cycles when the receiver takes them.
// When the receiver stalls, the output register holds its word, the back end stops and
// the queue fills; once it is full, serial ready drops until a slot frees.
// Reset clears the hunt state, the queue and the output valid; no result is pending.
module nmea_rmc_sentence_parser #(
  parameter int MAX_STORED = nmea_rmc_pkg::MAX_STORED_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  nmea_rmc_in_if.sink    serial,
  nmea_rmc_out_if.source fields
);

  logic               push;
  nmea_rmc_pkg::cmd_t push_cmd;
  logic               q_full;
  logic               head_valid;
  nmea_rmc_pkg::cmd_t head_cmd;
  logic               pop;

  // Front end: phase tracking, header check and comma counting turn each byte into at most
  // one record command.
  nmea_rmc_front #(
    .MAX_STORED (MAX_STORED)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .serial   (serial),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  nmea_rmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  // Back end: the record store and the sequencer that reads it out field by field.
  nmea_rmc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .fields     (fields)
  );

endmodule

@@ rtl/nmea_rmc_checker.sv @@
`timescale 1ns / 1ps

module nmea_rmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  field_number,
  input logic [15:0] text_high,
  input logic        last_field
);

  logic [3:0] expect_field;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_field <= 4'd1;
    end else if (out_valid && out_ready) begin
      expect_field <= last_field ? 4'd1 : field_number + 4'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_number))
    else $error("result word changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> field_number == expect_field)
    else $error("result fields out of order");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_field == (field_number == 4'd9))
    else $error("last_field does not mark field nine");

  // Only time and longitude reach character 9; latitude ends at character 8.
  a_short: assert property (@(posedge clk) disable iff (rst)
    out_valid && field_number != 4'd1 && field_number != 4'd5 |->
      (text_high[15:8] == 8'd0) && (field_number == 4'd3 || text_high[7:0] == 8'd0))
    else $error("text beyond field width is not zero");

endmodule

bind nmea_rmc_sentence_parser nmea_rmc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (fields.valid),
  .out_ready    (fields.ready),
  .field_number (fields.field_number),
  .text_high    (fields.text_high),
  .last_field   (fields.last_field)
);
